// ===== hdl/frm_pkg.sv =====
package frm_pkg;

   // Window of recent frame durations
   localparam int WINDOW  = 64;
   localparam int RING_AW = $clog2(WINDOW);
   localparam int FILL_W  = $clog2(WINDOW + 1);
   localparam int SUM_W   = 32 + RING_AW;

   // Field widths
   localparam int STAMP_W = 64;
   localparam int US_W    = 32;
   localparam int INDEX_W = 32;
   localparam int AVG_W   = 40;
   localparam int RATE_W  = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Tick delta to microseconds: 64 x 20 bit product, taken in two halves
   localparam int UNIT_W = 20;
   localparam int MUL_W  = 32 + UNIT_W;
   localparam int PROD_W = STAMP_W + UNIT_W;
   localparam logic [UNIT_W-1:0] UNIT_SEC  = UNIT_W'(1000000);
   localparam logic [UNIT_W-1:0] UNIT_MSEC = UNIT_W'(1000);

   // Rate numerator: unit scaled by 2^24
   localparam int RATE_SHIFT = 24;
   localparam int RNUM_W     = UNIT_W + RATE_SHIFT;

   // Shared serial divider
   localparam int DIV_W     = 40;
   localparam int DIV_CNT_W = 6;
   localparam logic [DIV_CNT_W-1:0] US_STEPS   = DIV_CNT_W'(32);
   localparam logic [DIV_CNT_W-1:0] AVG_STEPS  = DIV_CNT_W'(40);
   localparam logic [DIV_CNT_W-1:0] RATE_STEPS = DIV_CNT_W'(32);

   // Reset values
   localparam logic [31:0] TICK_FREQ_RESET = 32'd1000000;
   localparam logic [31:0] RATE_RESET      = 32'h0400_0000;
   localparam logic [31:0] U32_MAX         = 32'hFFFF_FFFF;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TICK_FREQ = 2'd0,
      CSR_PREC_MODE = 2'd1,
      CSR_PAUSED    = 2'd2
   } csr_idx_type;

   // Request actions
   localparam logic ACT_UPDATE  = 1'b0;
   localparam logic ACT_RESTART = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_SUM,
      ST_US_LD,
      ST_US_WAIT,
      ST_RING,
      ST_AVG_LD,
      ST_AVG_WAIT,
      ST_RATE_LD,
      ST_RATE_WAIT,
      ST_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic mul_lo;
      logic mul_hi;
      logic prod_sum;
      logic us_start;
      logic store_dur;
      logic ring_upd;
      logic avg_start;
      logic store_avg;
      logic rate_start;
      logic store_rate;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic win_needed;
      logic avg_nonzero;
      logic div_done;
      logic out_free;
   } ctrl_stat_type;

endpackage

// ===== hdl/frm_if.sv =====
// Request channel: one frame mark
interface frm_req_if;
   logic                       valid;
   logic                       ready;
   logic                       action;
   logic [frm_pkg::STAMP_W-1:0] time_stamp;
   logic [frm_pkg::STAMP_W-1:0] cycle_stamp;

   modport source (output valid, action, time_stamp, cycle_stamp, input ready);
   modport sink   (input valid, action, time_stamp, cycle_stamp, output ready);
endinterface

// Response channel: timing results of one update mark
interface frm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [frm_pkg::US_W-1:0]    frame_us;
   logic [frm_pkg::STAMP_W-1:0] frame_cycles;
   logic [frm_pkg::INDEX_W-1:0] frame_index;
   logic [frm_pkg::AVG_W-1:0]   average_us;
   logic [frm_pkg::RATE_W-1:0]  rate;

   modport source (output valid, frame_us, frame_cycles, frame_index, average_us, rate,
                   input ready);
   modport sink   (input valid, frame_us, frame_cycles, frame_index, average_us, rate,
                   output ready);
endinterface

// Register write channel
interface frm_csr_if;
   logic                           valid;
   logic                           ready;
   logic [frm_pkg::CSR_IDX_W-1:0]  index;
   logic [frm_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/frm_div.sv =====
module frm_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [frm_pkg::DIV_W-1:0]     rem_init,
   input  logic [frm_pkg::DIV_W-1:0]     q_init,
   input  logic [frm_pkg::DIV_W-1:0]     divisor,
   input  logic [frm_pkg::DIV_CNT_W-1:0] steps,
   output logic                          done,
   output logic [frm_pkg::DIV_W-1:0]     quot
);
   import frm_pkg::*;

   logic [DIV_W-1:0]     rem_ff, q_ff, div_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff, done_ff;

   logic [DIV_W:0]   rem_sh, rem_sub;
   logic             ge;
   logic [DIV_W-1:0] rem_in, q_in;

   // One restoring step: shift in next dividend bit, subtract if it fits
   always_comb begin
      rem_sh  = {rem_ff, q_ff[DIV_W-1]};
      ge      = rem_sh >= {1'b0, div_ff};
      rem_sub = rem_sh - {1'b0, div_ff};
      rem_in  = ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      q_in    = {q_ff[DIV_W-2:0], ge};
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= rem_init;
         q_ff   <= q_init;
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end
   end

   // Step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

// ===== hdl/frm_dpath.sv =====
module frm_dpath (
   input  logic                           clock,
   input  logic                           reset,
   input  frm_pkg::ctrl_cmd_type          cmd,
   output frm_pkg::ctrl_stat_type         stat,
   input  logic                           req_action,
   input  logic [frm_pkg::STAMP_W-1:0]    req_time_stamp,
   input  logic [frm_pkg::STAMP_W-1:0]    req_cycle_stamp,
   input  logic                           csr_we,
   input  logic [frm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [frm_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [frm_pkg::US_W-1:0]       rsp_frame_us,
   output logic [frm_pkg::STAMP_W-1:0]    rsp_frame_cycles,
   output logic [frm_pkg::INDEX_W-1:0]    rsp_frame_index,
   output logic [frm_pkg::AVG_W-1:0]      rsp_average_us,
   output logic [frm_pkg::RATE_W-1:0]     rsp_rate
);
   import frm_pkg::*;

   // Configuration
   logic [31:0] tick_freq_ff;
   logic        prec_mode_ff, paused_ff;

   // Frame state
   logic [STAMP_W-1:0] last_time_ff, last_cycles_ff, delta_ff, cyc_ff;
   logic [INDEX_W-1:0] counter_ff;
   logic [MUL_W-1:0]   prod_lo_ff, prod_hi_ff, mul_p;
   logic [31:0]        mul_a;
   logic [PROD_W-1:0]  prod_ff;
   logic [US_W-1:0]    dur_ff;
   logic [AVG_W-1:0]   avg_ff;
   logic [RATE_W-1:0]  rate_ff;
   logic               div_sat_ff;

   // Window
   logic [31:0]        ring_ff [WINDOW];
   logic [31:0]        ring_rd_ff;
   logic [FILL_W-1:0]  fill_ff;
   logic [RING_AW-1:0] slot_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic               ring_full;

   // Output register
   logic               rsp_valid_ff;
   logic [US_W-1:0]    out_us_ff;
   logic [STAMP_W-1:0] out_cyc_ff;
   logic [INDEX_W-1:0] out_idx_ff;
   logic [AVG_W-1:0]   out_avg_ff;
   logic [RATE_W-1:0]  out_rate_ff;

   // Divider hookup
   logic               div_start, div_done, us_sat, rate_sat;
   logic [DIV_W-1:0]   div_rem, div_q, div_d, div_quot;
   logic [DIV_CNT_W-1:0] div_steps;
   logic [RNUM_W-1:0]  rate_num;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_freq_ff <= TICK_FREQ_RESET;
         prec_mode_ff <= 1'b1;
         paused_ff    <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TICK_FREQ: tick_freq_ff <= csr_data;
            CSR_PREC_MODE: prec_mode_ff <= csr_data[0];
            CSR_PAUSED:    paused_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Request capture: timestamp bases, deltas and frame counter
   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff   <= '0;
         last_cycles_ff <= '0;
         counter_ff     <= '0;
      end else if (cmd.accept) begin
         last_time_ff <= req_time_stamp;
         if (req_action == ACT_UPDATE) begin
            last_cycles_ff <= req_cycle_stamp;
            if (!paused_ff) counter_ff <= counter_ff + INDEX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         delta_ff <= req_time_stamp - last_time_ff;
         cyc_ff   <= req_cycle_stamp - last_cycles_ff;
      end
   end

   // Tick delta times one million, one 32-bit half per cycle
   assign mul_a = cmd.mul_hi ? delta_ff[63:32] : delta_ff[31:0];
   assign mul_p = MUL_W'(mul_a) * MUL_W'(UNIT_SEC);

   always_ff @(posedge clock) begin
      if (cmd.mul_lo)   prod_lo_ff <= mul_p;
      if (cmd.mul_hi)   prod_hi_ff <= mul_p;
      if (cmd.prod_sum) prod_ff    <= {prod_hi_ff, 32'd0} + PROD_W'(prod_lo_ff);
   end

   // Divider operand select; duration and rate quotients beyond 32 bits saturate up front
   assign rate_num = prec_mode_ff ? {UNIT_SEC, RATE_SHIFT'(0)} : {UNIT_MSEC, RATE_SHIFT'(0)};

   always_comb begin
      div_start = cmd.us_start | cmd.avg_start | cmd.rate_start;
      us_sat    = prod_ff[PROD_W-1:32] >= (PROD_W-32)'(tick_freq_ff);
      rate_sat  = DIV_W'(rate_num[RNUM_W-1:32]) >= avg_ff;
      if (cmd.avg_start) begin
         div_rem   = DIV_W'(sum_ff[SUM_W-1:32]);
         div_q     = {sum_ff[31:0], 8'd0};
         div_d     = DIV_W'(fill_ff);
         div_steps = AVG_STEPS;
      end else if (cmd.rate_start) begin
         div_rem   = DIV_W'(rate_num[RNUM_W-1:32]);
         div_q     = {rate_num[31:0], 8'd0};
         div_d     = avg_ff;
         div_steps = RATE_STEPS;
      end else begin
         div_rem   = prod_ff[DIV_W+31:32];
         div_q     = {prod_ff[31:0], 8'd0};
         div_d     = DIV_W'(tick_freq_ff);
         div_steps = US_STEPS;
      end
   end

   frm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rem_init (div_rem),
      .q_init   (div_q),
      .divisor  (div_d),
      .steps    (div_steps),
      .done     (div_done),
      .quot     (div_quot)
   );

   // Saturation flag and quotient capture
   always_ff @(posedge clock) begin
      if (cmd.us_start)   div_sat_ff <= us_sat;
      if (cmd.rate_start) div_sat_ff <= rate_sat;
      if (cmd.store_dur)  dur_ff <= div_sat_ff ? U32_MAX : div_quot[US_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff  <= '0;
         rate_ff <= RATE_RESET;
      end else begin
         if (cmd.store_avg)  avg_ff  <= div_quot[AVG_W-1:0];
         if (cmd.store_rate) rate_ff <= div_sat_ff ? U32_MAX : div_quot[RATE_W-1:0];
      end
   end

   // Duration ring, read port always registered at the write slot
   always_ff @(posedge clock) begin
      if (cmd.ring_upd) ring_ff[slot_ff] <= dur_ff;
      ring_rd_ff <= ring_ff[slot_ff];
   end

   assign ring_full = fill_ff == FILL_W'(WINDOW);

   // Running sum, fill count and write slot
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         slot_ff <= '0;
         sum_ff  <= '0;
      end else if (cmd.ring_upd) begin
         sum_ff <= sum_ff - (ring_full ? SUM_W'(ring_rd_ff) : SUM_W'(0)) + SUM_W'(dur_ff);
         if (!ring_full) fill_ff <= fill_ff + FILL_W'(1);
         slot_ff <= (slot_ff == RING_AW'(WINDOW - 1)) ? '0 : slot_ff + RING_AW'(1);
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_us_ff   <= dur_ff;
         out_cyc_ff  <= cyc_ff;
         out_idx_ff  <= counter_ff;
         out_avg_ff  <= avg_ff;
         out_rate_ff <= rate_ff;
      end
   end

   // Status to controller
   always_comb begin
      stat.win_needed  = counter_ff > INDEX_W'(1);
      stat.avg_nonzero = avg_ff != '0;
      stat.div_done    = div_done;
      stat.out_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_us     = out_us_ff;
   assign rsp_frame_cycles = out_cyc_ff;
   assign rsp_frame_index  = out_idx_ff;
   assign rsp_average_us   = out_avg_ff;
   assign rsp_rate         = out_rate_ff;

endmodule

// ===== hdl/frm_ctrl.sv =====
module frm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_action,
   output logic                   req_ready,
   input  frm_pkg::ctrl_stat_type stat,
   output frm_pkg::ctrl_cmd_type  cmd
);
   import frm_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_action == ACT_UPDATE) state_in = ST_MUL_LO;
         end
         ST_MUL_LO:  state_in = ST_MUL_HI;
         ST_MUL_HI:  state_in = ST_SUM;
         ST_SUM:     state_in = ST_US_LD;
         ST_US_LD:   state_in = ST_US_WAIT;
         ST_US_WAIT: begin
            if (stat.div_done) state_in = stat.win_needed ? ST_RING : ST_RESP;
         end
         ST_RING:     state_in = ST_AVG_LD;
         ST_AVG_LD:   state_in = ST_AVG_WAIT;
         ST_AVG_WAIT: begin
            if (stat.div_done) state_in = ST_RATE_LD;
         end
         ST_RATE_LD:  state_in = stat.avg_nonzero ? ST_RATE_WAIT : ST_RESP;
         ST_RATE_WAIT: begin
            if (stat.div_done) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_MUL_LO:    cmd.mul_lo     = 1'b1;
         ST_MUL_HI:    cmd.mul_hi     = 1'b1;
         ST_SUM:       cmd.prod_sum   = 1'b1;
         ST_US_LD:     cmd.us_start   = 1'b1;
         ST_US_WAIT:   cmd.store_dur  = stat.div_done;
         ST_RING:      cmd.ring_upd   = 1'b1;
         ST_AVG_LD:    cmd.avg_start  = 1'b1;
         ST_AVG_WAIT:  cmd.store_avg  = stat.div_done;
         ST_RATE_LD:   cmd.rate_start = stat.avg_nonzero;
         ST_RATE_WAIT: cmd.store_rate = stat.div_done;
         ST_RESP:      cmd.load_out   = stat.out_free;
         default: ;
      endcase
   end

endmodule

// ===== hdl/frame_rate_meter.sv =====
// Channel   Dir  Payload                                                   Handshake
// req_chan  in   action, time_stamp, cycle_stamp                           valid/ready
// rsp_chan  out  frame_us, frame_cycles, frame_index, average_us, rate     valid/ready
// csr_chan  in   index (0 tick_frequency, 1 precision_mode, 2 paused), data  valid/ready
//
// A restart request finishes on accept. An update request blocks new requests while it
// runs the duration division, then, if the window is updated, the average division and,
// for a nonzero average, the rate division, on one shared radix-2 divider (32 steps for
// duration, 40 for average, 32 for rate). Synchronous active-high reset; the ring is not
// cleared. A finished response waits in an output register, so the next request is taken
// while it is stalled; a second result then waits until the first is taken.
module frame_rate_meter (
   input logic clock,
   input logic reset,
   frm_req_if.sink   req_chan,
   frm_rsp_if.source rsp_chan,
   frm_csr_if.sink   csr_chan
);
   import frm_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   assign csr_chan.ready = 1'b1;

   frm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .req_ready  (req_chan.ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   frm_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_action       (req_chan.action),
      .req_time_stamp   (req_chan.time_stamp),
      .req_cycle_stamp  (req_chan.cycle_stamp),
      .csr_we           (csr_chan.valid),
      .csr_index        (csr_chan.index),
      .csr_data         (csr_chan.data),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_frame_us     (rsp_chan.frame_us),
      .rsp_frame_cycles (rsp_chan.frame_cycles),
      .rsp_frame_index  (rsp_chan.frame_index),
      .rsp_average_us   (rsp_chan.average_us),
      .rsp_rate         (rsp_chan.rate)
   );

   // A restart request never produces a response
   a_restart_silent: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && req_chan.action == ACT_RESTART
      |=> !$rose(rsp_chan.valid))
      else $error("response raised after restart request");

   // An update request occupies the block
   a_update_busy: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && req_chan.action == ACT_UPDATE
      |=> !req_chan.ready)
      else $error("request taken while an update is in progress");

   // A response is only launched from the final step of an update
   a_resp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(!req_chan.ready))
      else $error("response launched while idle");

endmodule
